[hdl/kal_pkg.sv]
package kal_pkg;

    localparam int MAX_NODES   = 1023;
    localparam int LEVELS      = 10;
    localparam int NODE_W      = 10;
    localparam int LVL_W       = 4;
    localparam int ADDR_W      = LVL_W + NODE_W;
    localparam int TABLE_DEPTH = (MAX_NODES + 1) * LEVELS;

    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_BUILD = 2'd1;
    localparam logic [1:0] CMD_QUERY = 2'd2;

    typedef struct packed {
        logic [1:0]        command;
        logic [NODE_W-1:0] node;
        logic [NODE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [NODE_W-1:0] ancestor;
        logic              found;
    } out_item_t;

    typedef struct packed {
        logic load_item;
        logic clear_en;
        logic set_en;
        logic rd_mid;
        logic rd_anc;
        logic build_wr;
        logic walk_step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic cnt_zero;
        logic node_last;
        logic level_last;
        logic walk_last;
    } dp_stat_t;

endpackage

[hdl/kal_datapath.sv]
module kal_datapath import kal_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [NODE_W-1:0]   cfg_wdata,
    input  in_item_t            item,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    output logic                done,
    output out_item_t           result
);

    logic [NODE_W-1:0] table_mem [TABLE_DEPTH];

    logic [NODE_W-1:0] node_count_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    in_item_t          item_reg;
    logic [LVL_W-1:0]  lvl_reg;
    logic [NODE_W-1:0] bv_reg;
    logic [NODE_W-1:0] v_reg;
    logic              took_reg;
    logic [NODE_W-1:0] rdata_reg;
    logic              done_reg;
    out_item_t         result_reg;

    logic [NODE_W-1:0] cnt;
    logic [LVL_W-1:0]  lvl_m1;
    logic [NODE_W-1:0] v_sel;
    logic              re;
    logic [ADDR_W-1:0] raddr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [NODE_W-1:0] wdata;
    logic              set_ok;
    logic              q_ok;
    out_item_t         result_next;

    assign cnt    = (node_count_reg > NODE_W'(MAX_NODES)) ? NODE_W'(MAX_NODES) : node_count_reg;
    assign lvl_m1 = lvl_reg - LVL_W'(1);
    // the walk feeds the previous read straight back as the next row
    assign v_sel  = took_reg ? rdata_reg : v_reg;

    assign stat.clear_last = (clr_addr_reg == ADDR_W'(TABLE_DEPTH - 1));
    assign stat.cnt_zero   = (cnt == '0);
    assign stat.node_last  = (bv_reg == cnt);
    assign stat.level_last = (lvl_reg == LVL_W'(LEVELS - 1));
    assign stat.walk_last  = (lvl_reg == '0);

    assign set_ok = (item_reg.node != '0) && (item_reg.node <= cnt);

    always_comb
    begin
        re    = 1'b0;
        raddr = '0;
        if (cmd.rd_mid)
        begin
            re    = 1'b1;
            raddr = {lvl_m1, bv_reg};
        end
        else if (cmd.rd_anc)
        begin
            re    = 1'b1;
            raddr = {lvl_m1, rdata_reg};
        end
        else if (cmd.walk_step)
        begin
            re    = item_reg.value[lvl_reg];
            raddr = {lvl_reg, v_sel};
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = '0;
        wdata = '0;
        if (cmd.clear_en)
        begin
            we    = 1'b1;
            waddr = clr_addr_reg;
        end
        else if (cmd.set_en)
        begin
            we    = set_ok;
            waddr = {LVL_W'(0), item_reg.node};
            wdata = (item_reg.value <= cnt) ? item_reg.value : '0;
        end
        else if (cmd.build_wr)
        begin
            we    = 1'b1;
            waddr = {lvl_reg, bv_reg};
            wdata = rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            table_mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= table_mem[raddr];
        end
    end

    always_comb
    begin
        q_ok = (item_reg.node != '0) && (item_reg.node <= cnt)
            && ((item_reg.value >> LEVELS) == '0) && (v_sel != '0);
        result_next.ancestor = q_ok ? v_sel : '0;
        result_next.found    = q_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_W'(1023);
            clr_addr_reg   <= '0;
            done_reg       <= 1'b0;
            took_reg       <= 1'b0;
            lvl_reg        <= '0;
            bv_reg         <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
            end
            done_reg <= cmd.finish;
            if (cmd.load_item)
            begin
                took_reg <= 1'b0;
                bv_reg   <= NODE_W'(1);
                lvl_reg  <= (item.command == CMD_BUILD) ? LVL_W'(1) : LVL_W'(LEVELS - 1);
            end
            else if (cmd.walk_step)
            begin
                took_reg <= item_reg.value[lvl_reg];
                lvl_reg  <= lvl_reg - LVL_W'(1);
            end
            else if (cmd.build_wr)
            begin
                if (stat.node_last)
                begin
                    bv_reg  <= NODE_W'(1);
                    lvl_reg <= lvl_reg + LVL_W'(1);
                end
                else
                begin
                    bv_reg <= bv_reg + NODE_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= item;
            v_reg    <= item.node;
        end
        else if (cmd.walk_step)
        begin
            v_reg <= v_sel;
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

[hdl/kal_ctrl.sv]
module kal_ctrl import kal_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  logic [1:0] command,
    input  dp_stat_t   stat,
    output logic       busy,
    output dp_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_SET   = 8'b0000_0100,
        S_BMID  = 8'b0000_1000,
        S_BANC  = 8'b0001_0000,
        S_BWR   = 8'b0010_0000,
        S_WALK  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load_item = 1'b1;
                    unique case (command)
                        CMD_SET:   state_next = S_SET;
                        CMD_BUILD: state_next = stat.cnt_zero ? S_IDLE : S_BMID;
                        CMD_QUERY: state_next = S_WALK;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SET:
            begin
                cmd.set_en = 1'b1;
                state_next = S_IDLE;
            end
            S_BMID:
            begin
                cmd.rd_mid = 1'b1;
                state_next = S_BANC;
            end
            S_BANC:
            begin
                cmd.rd_anc = 1'b1;
                state_next = S_BWR;
            end
            S_BWR:
            begin
                cmd.build_wr = 1'b1;
                state_next   = (stat.node_last && stat.level_last) ? S_IDLE : S_BMID;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (stat.walk_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/kth_ancestor_binary_lifting.sv]
// binary-lifting kth-ancestor engine: after reset the block zeroes all TABLE_DEPTH (10240) entries
// of the ancestor table with busy high; config writes are taken at any time. a beat is
// accepted when start is high and busy is low. a build beat does two dependent reads and
// one write per node and level (levels 1 to LEVELS - 1), and a query beat does at most one
// table read per level, with done and result shown for one cycle at the end; the receiver
// cannot stall it
module kth_ancestor_binary_lifting import kal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  in_item_t          item,
    output logic              done,
    output out_item_t         result,
    input  logic              cfg_we,
    input  logic [NODE_W-1:0] cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    kal_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .command (item.command),
        .stat    (stat),
        .busy    (busy),
        .cmd     (cmd)
    );

    kal_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

`ifndef SYNTHESIS
    a_done_after_busy : assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding busy cycle");

    a_done_single : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held longer than one cycle");

    a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.ancestor == '0))
        else $error("not-found result carries a nonzero ancestor");

    a_one_cmd : assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("controller issued more than one datapath command");
`endif

endmodule

[tb/kal_checker.sv]
module kal_checker import kal_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  in_item_t          item,
    input  logic              done,
    input  out_item_t         result,
    input  logic              cfg_we,
    input  logic [NODE_W-1:0] cfg_wdata,
    output int                fail_count,
    output int                pending
);

    // level 0 holds the parents, level i the 2^i-step ancestors
    logic [NODE_W-1:0] lift_tbl [0:MAX_NODES][0:LEVELS-1];
    logic [NODE_W-1:0] node_limit;
    out_item_t         ancestor_q[$];

    function automatic int nodes_live();
        return (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
    endfunction

    function automatic out_item_t walk_up(logic [NODE_W-1:0] from_node,
                                          logic [NODE_W-1:0] steps);
        out_item_t         res;
        logic [NODE_W-1:0] at;
        logic              ok;
        at = from_node;
        ok = (from_node >= 1) && (from_node <= nodes_live());
        if (ok && LEVELS < 16 && (steps >> LEVELS) != 0)
            ok = 1'b0;
        if (ok)
        begin
            for (int i = LEVELS - 1; i >= 0; i--)
            begin
                if (steps[i])
                    at = lift_tbl[at][i];
            end
            if (at == 0)
                ok = 1'b0;
        end
        res.ancestor = ok ? at : '0;
        res.found    = ok;
        return res;
    endfunction

    task automatic rebuild_lifting();
        logic [NODE_W-1:0] mid;
        for (int lvl = 1; lvl < LEVELS; lvl++)
        begin
            for (int v = 1; v <= nodes_live(); v++)
            begin
                mid = lift_tbl[v][lvl-1];
                lift_tbl[v][lvl] = lift_tbl[mid][lvl-1];
            end
        end
    endtask

    task automatic apply_beat(in_item_t beat);
        int cnt;
        cnt = nodes_live();
        case (beat.command)
            CMD_SET:
            begin
                if (beat.node >= 1 && beat.node <= cnt)
                    lift_tbl[beat.node][0] = (beat.value <= cnt) ? beat.value : '0;
            end
            CMD_BUILD:
                rebuild_lifting();
            CMD_QUERY:
                ancestor_q.insert(ancestor_q.size(), walk_up(beat.node, beat.value));
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r <= MAX_NODES; r++)
            begin
                for (int l = 0; l < LEVELS; l++)
                    lift_tbl[r][l] = '0;
            end
            node_limit = 10'd1023;
            ancestor_q.delete();
            fail_count = 0;
            pending    = 0;
        end
        else
        begin : track
            out_item_t want;
            if (done)
            begin
                if (ancestor_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none, got %0d found %0b",
                             $time, result.ancestor, result.found);
                    fail_count++;
                end
                else
                begin
                    want = ancestor_q.pop_front();
                    if (result.ancestor !== want.ancestor || result.found !== want.found)
                    begin
                        $display("%0t: mismatch: expected %0d found %0b, got %0d found %0b",
                                 $time, want.ancestor, want.found,
                                 result.ancestor, result.found);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                node_limit = cfg_wdata;
            if (start && !busy)
                apply_beat(item);
            pending = ancestor_q.size();
        end
    end

endmodule

[tb/testbench.sv]
module testbench;
    import kal_pkg::*;

    localparam logic [1:0] CMD_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 2_000_000;
    localparam int         ITEM_GOAL   = 520;
    localparam int         QUIET_FROM  = 440;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    in_item_t          item;
    logic              done;
    out_item_t         result;
    logic              cfg_we;
    logic [NODE_W-1:0] cfg_wdata;
    int                fail_count;
    int                pending;
    int                cycles = 0;
    int                items_sent;
    bit                gaps_on;

    kth_ancestor_binary_lifting i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    kal_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .item       (item),
        .done       (done),
        .result     (result),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send(input logic [1:0] cmd, input int nd, input int val);
        in_item_t beat;
        beat.command = cmd;
        beat.node    = nd[NODE_W-1:0];
        beat.value   = val[NODE_W-1:0];
        start <= 1'b1;
        item  <= beat;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
        if (cmd != CMD_UNUSED)
            items_sent++;
    endtask

    task automatic maybe_gap();
        if (gaps_on && items_sent < QUIET_FROM && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            item  <= in_item_t'($urandom);
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0 || busy);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_count(input int n);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= n[NODE_W-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= NODE_W'($urandom);
        @(negedge clk);
    endtask

    task automatic query_beat(input int cnt);
        int nd;
        int steps;
        if ($urandom_range(0, 15) == 0)
            nd = $urandom_range(0, 1023);
        else
            nd = $urandom_range(1, cnt);
        if ($urandom_range(0, 3) == 0)
            steps = $urandom_range(0, 1023);
        else
            steps = $urandom_range(0, nd + 1) & 1023;
        if ($urandom_range(0, 19) == 0)
            drain();
        send(CMD_QUERY, nd, steps);
    endtask

    // junk beats: out-of-range sets, loops, unused command, random queries
    task automatic noise_beat();
        case ($urandom_range(0, 2))
            0: send(CMD_SET, $urandom_range(0, 1023), $urandom_range(0, 1023));
            1: send(CMD_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 1023));
            default: send(CMD_QUERY, $urandom_range(0, 1023), $urandom_range(0, 1023));
        endcase
    endtask

    task automatic run_phase(input int p);
        int cnt;
        int rounds;
        int nsets;
        int v;
        int par;
        case (p)
            0: cnt = 1;
            1: cnt = 1023;
            2: cnt = 1000;
            default:
                cnt = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                                  : $urandom_range(2, 48);
        endcase
        write_count(cnt);
        gaps_on = ($urandom_range(0, 3) != 0);
        rounds  = (cnt > 64) ? 1 : $urandom_range(1, 2);
        for (int r = 0; r < rounds; r++)
        begin
            nsets = (cnt > 40) ? 40 : cnt;
            for (int i = 0; i < nsets; i++)
            begin
                maybe_gap();
                if ($urandom_range(0, 9) == 0)
                    noise_beat();
                else
                begin
                    // mostly chains so that deep walks stay inside the tree
                    v = (cnt > 40) ? $urandom_range(1, cnt) : i + 1;
                    if (v == 1)
                        par = 0;
                    else if ($urandom_range(0, 3) != 0)
                        par = v - 1;
                    else
                        par = $urandom_range(0, v - 1);
                    send(CMD_SET, v, par);
                end
            end
            if ($urandom_range(0, 2) == 0)
            begin
                repeat (3)
                begin
                    maybe_gap();
                    query_beat(cnt);
                end
            end
            maybe_gap();
            send(CMD_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023));
            repeat ($urandom_range(15, 30))
            begin
                maybe_gap();
                query_beat(cnt);
            end
        end
    endtask

    initial
    begin
        int p;
        clk        = 1'b0;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        items_sent = 0;
        gaps_on    = 1'b0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // default node count of 1023
        send(CMD_QUERY, 1023, 0);
        send(CMD_SET, 1023, 1022);
        send(CMD_QUERY, 1023, 1);
        send(CMD_QUERY, 1023, 2);          // level 1 not built yet

        write_count(7);
        send(CMD_SET, 2, 1);
        send(CMD_SET, 3, 2);
        send(CMD_SET, 4, 3);
        send(CMD_SET, 5, 4);
        send(CMD_SET, 6, 1);
        send(CMD_SET, 7, 1023);            // parent beyond count reads as root
        send(CMD_SET, 0, 3);               // none sentinel is never written
        send(CMD_SET, 1023, 1);            // node beyond count ignored
        send(CMD_UNUSED, 5, 5);
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 5, 0);
        send(CMD_QUERY, 5, 4);
        send(CMD_QUERY, 5, 5);
        send(CMD_QUERY, 5, 1023);
        send(CMD_QUERY, 0, 0);
        send(CMD_QUERY, 1023, 0);
        send(CMD_SET, 7, 7);               // self loop
        send(CMD_BUILD, 0, 0);
        send(CMD_QUERY, 7, 1023);
        send(CMD_QUERY, 6, 1);

        p = 0;
        while (items_sent < ITEM_GOAL)
        begin
            run_phase(p);
            p++;
        end

        drain();
        repeat (LEVELS + 4) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
